>>> hw/rtl/sfsf_pkg.sv
`default_nettype none

package sfsf_pkg;

	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam int UNDEF_LEN = 5;

	localparam int ACC_W = 17;
	localparam logic [ACC_W-1:0] VALUE_LIMIT = 17'd99999;
	localparam logic [ACC_W-1:0] ACC_SAT = 17'd100000;

	localparam logic [7:0] LIMIT_RESET = 8'd5;

	localparam int VAL_W = 18;
	localparam int CNT_OUT_W = 16;

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_WEIGHT = 2'd1,
		ST_UNDEF = 2'd2,
		ST_ZERO = 2'd3
	} status_t;

	// number scan position inside the payload
	typedef enum logic [1:0] {
		PH_LEAD = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic neg;
		logic [ACC_W-1:0] acc;
		logic all_i;
	} scan_t;

	typedef struct packed {
		logic ready_res;
		logic signed [VAL_W-1:0] weight;
		status_t frame_status;
		logic signed [VAL_W-1:0] reading;
		logic [CNT_OUT_W-1:0] stable_count;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

`default_nettype wire

>>> hw/rtl/sfsf_scan.sv
`default_nettype none

// One payload byte of atoi-style scan, plus the IIIII tracking.
module sfsf_scan (
	input  sfsf_pkg::scan_t cur,
	input  logic [7:0]      rx_byte,
	output sfsf_pkg::scan_t nxt
);

	logic is_ws;
	logic is_sign;
	logic is_digit;
	logic [3:0] digit;
	logic [20:0] acc_x10;
	logic [20:0] acc_sum;
	logic [sfsf_pkg::ACC_W-1:0] acc_step;

	always_comb begin
		is_ws = (rx_byte == sfsf_pkg::CH_SPACE) ||
			((rx_byte >= sfsf_pkg::CH_TAB) && (rx_byte <= sfsf_pkg::CH_CR));
		is_sign = (rx_byte == sfsf_pkg::CH_PLUS) || (rx_byte == sfsf_pkg::CH_MINUS);
		is_digit = (rx_byte >= sfsf_pkg::CH_ZERO) && (rx_byte <= sfsf_pkg::CH_NINE);
		digit = 4'(rx_byte - sfsf_pkg::CH_ZERO);
		acc_x10 = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0};
		acc_sum = acc_x10 + {17'd0, digit};
		// clamp one past the limit so the final clamp still sees overflow
		acc_step = (acc_sum > {4'd0, sfsf_pkg::ACC_SAT}) ? sfsf_pkg::ACC_SAT :
			acc_sum[sfsf_pkg::ACC_W-1:0];

		nxt = cur;
		nxt.all_i = cur.all_i && (rx_byte == sfsf_pkg::CH_I);
		unique case (cur.phase)
			sfsf_pkg::PH_LEAD: begin
				if (is_ws) begin
					nxt.phase = sfsf_pkg::PH_LEAD;
				end else if (is_sign) begin
					nxt.phase = sfsf_pkg::PH_DIGITS;
					nxt.neg = (rx_byte == sfsf_pkg::CH_MINUS);
				end else if (is_digit) begin
					nxt.phase = sfsf_pkg::PH_DIGITS;
					nxt.acc = {13'd0, digit};
				end else begin
					nxt.phase = sfsf_pkg::PH_DONE;
				end
			end
			sfsf_pkg::PH_DIGITS: begin
				if (is_digit) begin
					nxt.acc = acc_step;
				end else begin
					nxt.phase = sfsf_pkg::PH_DONE;
				end
			end
			default: begin
				nxt.phase = sfsf_pkg::PH_DONE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/sfsf_step.sv
`default_nettype none

// Frame tracking and stability state; result is the state after the item.
module sfsf_step #(
	parameter int PAYLOAD_MAX = 5,
	parameter int COUNT_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [7:0]       cfg_wr_data,
	input  logic             valid_s1,
	input  logic             cmd_s1,
	input  logic [7:0]       rx_byte_s1,
	output logic             res_valid,
	output sfsf_pkg::res_t   res
);

	localparam int LEN_W = $clog2(PAYLOAD_MAX + 1);
	localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(PAYLOAD_MAX);

	logic [7:0] limit_q;
	logic in_frame_q, in_frame_d;
	logic [LEN_W-1:0] len_q, len_d;
	sfsf_pkg::scan_t scan_q, scan_d, scan_step;
	logic signed [sfsf_pkg::VAL_W-1:0] last_q, last_d;
	logic signed [sfsf_pkg::VAL_W-1:0] held_q, held_d;
	logic [COUNT_BITS-1:0] count_q, count_d;
	logic ready_q, ready_d;
	sfsf_pkg::status_t status;

	logic is_undef;
	logic [sfsf_pkg::ACC_W-1:0] mag;
	logic signed [sfsf_pkg::VAL_W-1:0] value;
	sfsf_pkg::scan_t scan_init;

	sfsf_scan u_scan (
		.cur     (scan_q),
		.rx_byte (rx_byte_s1),
		.nxt     (scan_step)
	);

	always_comb begin
		scan_init.phase = sfsf_pkg::PH_LEAD;
		scan_init.neg = 1'b0;
		scan_init.acc = '0;
		scan_init.all_i = 1'b1;

		is_undef = (PAYLOAD_MAX >= sfsf_pkg::UNDEF_LEN) &&
			({{(32-LEN_W){1'b0}}, len_q} == 32'(sfsf_pkg::UNDEF_LEN)) && scan_q.all_i;
		mag = (scan_q.acc > sfsf_pkg::VALUE_LIMIT) ? sfsf_pkg::VALUE_LIMIT : scan_q.acc;
		value = scan_q.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

		in_frame_d = in_frame_q;
		len_d = len_q;
		scan_d = scan_q;
		last_d = last_q;
		held_d = held_q;
		count_d = count_q;
		ready_d = ready_q;
		status = sfsf_pkg::ST_NONE;

		if (valid_s1) begin
			if (cmd_s1) begin
				ready_d = 1'b0;
			end else if (rx_byte_s1 == sfsf_pkg::CH_STX) begin
				in_frame_d = 1'b1;
				len_d = '0;
				scan_d = scan_init;
			end else if (in_frame_q) begin
				if (rx_byte_s1 == sfsf_pkg::CH_ETX) begin
					in_frame_d = 1'b0;
					len_d = '0;
					if (is_undef || (mag == '0)) begin
						status = is_undef ? sfsf_pkg::ST_UNDEF : sfsf_pkg::ST_ZERO;
						if (count_q != '0) begin
							count_d = count_q - 1'b1;
						end
					end else begin
						status = sfsf_pkg::ST_WEIGHT;
						if (value == last_q) begin
							if (count_q == COUNT_BITS'(limit_q)) begin
								held_d = value;
								ready_d = 1'b1;
							end
							if (count_q != '1) begin
								count_d = count_q + 1'b1;
							end
						end else begin
							last_d = value;
						end
					end
				end else if (len_q != LEN_FULL) begin
					len_d = len_q + 1'b1;
					scan_d = scan_step;
				end
			end
		end

		res_valid = valid_s1;
		res.ready_res = ready_d;
		res.weight = held_d;
		res.frame_status = status;
		res.reading = last_d;
		res.stable_count = sfsf_pkg::CNT_OUT_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sfsf_pkg::LIMIT_RESET;
			in_frame_q <= 1'b0;
			len_q <= '0;
			last_q <= '0;
			held_q <= '0;
			count_q <= '0;
			ready_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			in_frame_q <= in_frame_d;
			len_q <= len_d;
			last_q <= last_d;
			held_q <= held_d;
			count_q <= count_d;
			ready_q <= ready_d;
		end
	end

	// scan state only matters once STX has initialized it
	always_ff @(posedge clk) begin
		scan_q <= scan_d;
	end

endmodule

`default_nettype wire

>>> hw/rtl/sfsf_obuf.sv
`default_nettype none

// Two-entry result buffer in front of the master port.
module sfsf_obuf (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [sfsf_pkg::RES_W-1:0]     push_data,
	input  logic                           pop,
	output logic                           not_empty,
	output logic [sfsf_pkg::RES_W-1:0]     head,
	output logic [1:0]                     level
);

	logic [sfsf_pkg::RES_W-1:0] mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] level_q;

	assign not_empty = (level_q != 2'd0);
	assign head = mem_q[rd_ptr_q];
	assign level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			level_q <= level_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/scale_frame_stability_filter_unit.sv
`default_nettype none

// Channel   Dir  Fields (tdata / tuser, low bit first)
// --------  ---  ------------------------------------------------------------
// s_*       in   tdata: rx_byte[7:0]; tuser: cmd (1 = host read, clears ready)
// m_*       out  tdata: ready_res, weight[17:0], reading[17:0],
//                stable_count[15:0], zero fill; tuser: frame_status[1:0]
// cfg_*     in   cfg_wr_data: stable_limit, written when cfg_wr_en is high
//
// Each transaction is registered into stage 1, handled by combinational
// logic, and its result lands in a two-entry output buffer on the next
// edge; m_tvalid follows the s-side accept after the stage 1 register and
// the buffer, and one transaction per cycle is sustained when m_tready
// stays high.
// s_tready drops only while the output buffer (after this cycle's pop) plus
// stage 1 hold two results.
// arst_n clears framing, counter, readings, ready flag and stable_limit (5).
module scale_frame_stability_filter_unit #(
	parameter int PAYLOAD_MAX = 5,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [0] ready_res, [18:1] weight, [36:19] reading,
	                               // [52:37] stable_count, [55:53] zero
	output logic [1:0]  m_tuser,   // [1:0] frame_status
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);

	logic valid_s1;
	logic cmd_s1;
	logic [7:0] rx_byte_s1;
	logic s_accept;
	logic pop;
	logic res_valid;
	sfsf_pkg::res_t res;
	sfsf_pkg::res_t head;
	logic [1:0] level;
	logic [1:0] level_after_pop;

	assign s_accept = s_tvalid && s_tready;
	assign pop = m_tvalid && m_tready;

	// room check counts the result still in stage 1
	assign level_after_pop = level - {1'b0, pop};
	assign s_tready = ({1'b0, level_after_pop} + {2'b00, valid_s1}) < 3'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1 <= s_tuser[0];
			rx_byte_s1 <= s_tdata;
		end
	end

	sfsf_step #(
		.PAYLOAD_MAX (PAYLOAD_MAX),
		.COUNT_BITS  (COUNT_BITS)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.valid_s1    (valid_s1),
		.cmd_s1      (cmd_s1),
		.rx_byte_s1  (rx_byte_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	sfsf_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (pop),
		.not_empty (m_tvalid),
		.head      (head),
		.level     (level)
	);

	assign m_tdata = {3'b000, head.stable_count, head.reading, head.weight, head.ready_res};
	assign m_tuser = head.frame_status;

	// the buffer never has to take a result it has no room for
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (level_after_pop != 2'd2))
		else $error("result buffer overflow");

	// a host read never reports a frame and always leaves ready cleared
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cmd_s1) |-> (res.frame_status == sfsf_pkg::ST_NONE && !res.ready_res))
		else $error("read command result wrong");

	// a weight frame always leaves a nonzero last reading
	a_weight_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.frame_status == sfsf_pkg::ST_WEIGHT) |-> (res.reading != '0))
		else $error("weight frame with zero reading");

endmodule

`default_nettype wire

>>> bench/scale_frame_stability_filter_unit_tb.sv
`timescale 1ns / 100ps

module scale_frame_stability_filter_unit_tb;

	localparam int PAYLOAD_KEEP = 5;
	localparam int CYCLE_LIMIT = 1000000;

	// Predicts one result per transaction: frame parsing, stability counter,
	// latched weight and ready flag, then checks the DUT output against it.
	class stability_scoreboard;
		bit [7:0] limit;
		bit framing;
		bit [7:0] chars [PAYLOAD_KEEP];
		int unsigned kept;
		int last_val;
		int held_val;
		bit [15:0] count;
		bit ready;
		sfsf_pkg::res_t expected_q[$];
		int unsigned n_inputs, n_results, n_errors, n_latches;
		int unsigned n_status [4];

		function new();
			limit = sfsf_pkg::LIMIT_RESET;
		endfunction

		function void note_input(bit rd, bit [7:0] rx);
			sfsf_pkg::status_t st;
			sfsf_pkg::res_t exp;
			int i;
			int acc;
			int v;
			bit neg;
			bit undef;
			st = sfsf_pkg::ST_NONE;
			n_inputs++;
			if (rd) begin
				ready = 1'b0;
			end else if (rx == sfsf_pkg::CH_STX) begin
				// STX opens a frame, or restarts one already open
				framing = 1'b1;
				kept = 0;
			end else if (framing) begin
				if (rx == sfsf_pkg::CH_ETX) begin
					undef = (kept == sfsf_pkg::UNDEF_LEN);
					for (i = 0; i < kept; i++)
						if (chars[i] != sfsf_pkg::CH_I)
							undef = 1'b0;
					// atoi style: whitespace, one sign, digits up to the first non-digit
					i = 0;
					acc = 0;
					neg = 1'b0;
					while (i < kept && (chars[i] == sfsf_pkg::CH_SPACE ||
					                    (chars[i] >= sfsf_pkg::CH_TAB &&
					                     chars[i] <= sfsf_pkg::CH_CR)))
						i++;
					if (i < kept && (chars[i] == sfsf_pkg::CH_PLUS ||
					                 chars[i] == sfsf_pkg::CH_MINUS)) begin
						neg = (chars[i] == sfsf_pkg::CH_MINUS);
						i++;
					end
					while (i < kept && chars[i] >= sfsf_pkg::CH_ZERO &&
					       chars[i] <= sfsf_pkg::CH_NINE) begin
						acc = acc * 10 + (chars[i] - sfsf_pkg::CH_ZERO);
						if (acc > sfsf_pkg::VALUE_LIMIT)
							acc = sfsf_pkg::ACC_SAT;
						i++;
					end
					if (acc > sfsf_pkg::VALUE_LIMIT)
						acc = sfsf_pkg::VALUE_LIMIT;
					v = neg ? -acc : acc;
					if (undef || v == 0) begin
						st = undef ? sfsf_pkg::ST_UNDEF : sfsf_pkg::ST_ZERO;
						if (count != 0)
							count = count - 1'b1;
					end else if (v == last_val) begin
						st = sfsf_pkg::ST_WEIGHT;
						if (count == limit) begin
							held_val = v;
							ready = 1'b1;
							n_latches++;
						end
						if (count != 16'hFFFF)
							count = count + 1'b1;
					end else begin
						st = sfsf_pkg::ST_WEIGHT;
						last_val = v;
					end
					framing = 1'b0;
					kept = 0;
				end else if (kept < PAYLOAD_KEEP) begin
					chars[kept] = rx;
					kept++;
				end
			end
			exp.ready_res = ready;
			exp.weight = held_val[sfsf_pkg::VAL_W-1:0];
			exp.frame_status = st;
			exp.reading = last_val[sfsf_pkg::VAL_W-1:0];
			exp.stable_count = count;
			expected_q = {expected_q, exp};
			n_status[st]++;
		endfunction

		function void check_field(string name, logic signed [31:0] want, logic signed [31:0] seen);
			if (want !== seen) begin
				$error("%s: expected %0d, got %0d", name, want, seen);
				n_errors++;
			end
		endfunction

		function void check_result(sfsf_pkg::res_t got);
			sfsf_pkg::res_t exp;
			if (expected_q.size() == 0) begin
				$error("result transaction with nothing expected (frame_status %0d)",
				       got.frame_status);
				n_errors++;
				return;
			end
			exp = expected_q.pop_front();
			n_results++;
			check_field("ready_res", exp.ready_res, got.ready_res);
			check_field("weight", exp.weight, got.weight);
			check_field("frame_status", exp.frame_status, got.frame_status);
			check_field("reading", exp.reading, got.reading);
			check_field("stable_count", exp.stable_count, got.stable_count);
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic [0:0]  s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = 8'h00;

	stability_scoreboard sb = new();
	int send_idle_pct = 25;
	int recv_idle_pct = 87;
	int unsigned cycles = 0;
	sfsf_pkg::res_t mon_res;
	bit [7:0] frame_body[$];
	bit [7:0] repeat_text[$];

	scale_frame_stability_filter_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("scale_frame_stability_filter_unit_tb failed");
			$finish;
		end
	end

	// receiver: random backpressure at the current rate
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// result monitor; sampled values are the ones from before the edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			mon_res.ready_res = m_tdata[0];
			mon_res.weight = m_tdata[18:1];
			mon_res.reading = m_tdata[36:19];
			mon_res.stable_count = m_tdata[52:37];
			mon_res.frame_status = sfsf_pkg::status_t'(m_tuser);
			sb.check_result(mon_res);
		end
	end

	// One transaction on the s side; random idle cycles ahead of it.
	task automatic send_item(bit rd, bit [7:0] rx);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rx;
		s_tuser <= rd;
		do @(posedge clk); while (!s_tready);
		sb.note_input(rd, rx);
	endtask

	task automatic send_body_frame();
		send_item(1'b0, sfsf_pkg::CH_STX);
		foreach (frame_body[i])
			send_item(1'b0, frame_body[i]);
		send_item(1'b0, sfsf_pkg::CH_ETX);
	endtask

	task automatic send_text_frame(string txt);
		frame_body.delete();
		for (int i = 0; i < txt.len(); i++)
			frame_body = {frame_body, 8'(txt[i])};
		send_body_frame();
	endtask

	// hold the sender until every expected result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(bit [7:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.limit = v;
	endtask

	// Mostly well-formed frames, with a repeated reading so the counter climbs;
	// the rest is reads, stray bytes, garbage payloads and unterminated frames.
	task automatic random_transaction();
		int pick;
		int n;
		int k;
		pick = $urandom_range(99);
		frame_body.delete();
		if (pick < 40) begin
			frame_body = repeat_text;
			send_body_frame();
		end else if (pick < 58) begin
			repeat_text.delete();
			if ($urandom_range(3) == 0) begin
				k = $urandom_range(5);
				repeat_text = {repeat_text,
				               8'(k == 0 ? sfsf_pkg::CH_SPACE : sfsf_pkg::CH_TAB + k - 1)};
			end
			k = $urandom_range(2);
			if (k == 1)
				repeat_text = {repeat_text, sfsf_pkg::CH_PLUS};
			else if (k == 2)
				repeat_text = {repeat_text, sfsf_pkg::CH_MINUS};
			n = $urandom_range(1, 5);
			repeat (n) repeat_text = {repeat_text, 8'(sfsf_pkg::CH_ZERO + $urandom_range(9))};
			frame_body = repeat_text;
			send_body_frame();
		end else if (pick < 64) begin
			// four, five or six 'I': five or six fill the kept payload with 'I', the undefined code
			n = $urandom_range(4, 6);
			repeat (n) frame_body = {frame_body, sfsf_pkg::CH_I};
			send_body_frame();
		end else if (pick < 70) begin
			case ($urandom_range(3))
				0: send_text_frame("");
				1: send_text_frame("0");
				2: send_text_frame("-00");
				default: send_text_frame(" +0");
			endcase
		end else if (pick < 78) begin
			n = $urandom_range(7);
			repeat (n) frame_body = {frame_body, 8'($urandom_range(255))};
			send_body_frame();
		end else if (pick < 86) begin
			send_item(1'b1, 8'($urandom_range(255)));
		end else if (pick < 93) begin
			send_item(1'b0, 8'($urandom_range(255)));
		end else begin
			send_item(1'b0, sfsf_pkg::CH_STX);
			n = $urandom_range(3);
			repeat (n) send_item(1'b0, 8'(sfsf_pkg::CH_ZERO + $urandom_range(9)));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reads, bytes outside a frame, restart, overflow, codes
		send_item(1'b1, 8'hFF);
		send_item(1'b0, sfsf_pkg::CH_ETX);
		send_item(1'b0, 8'hA5);
		send_item(1'b0, sfsf_pkg::CH_STX);
		send_item(1'b0, sfsf_pkg::CH_NINE);
		send_text_frame("+99999");
		send_text_frame("IIIII");
		send_text_frame("");
		send_text_frame("\t-7");
		repeat_text.delete();
		repeat_text = {repeat_text, sfsf_pkg::CH_NINE};
		drain();

		write_limit(8'd0);
		while (sb.n_inputs < 160)
			random_transaction();
		drain();
		while (sb.n_inputs < 300)
			random_transaction();
		drain();

		write_limit(8'd7);
		send_idle_pct = 87;
		recv_idle_pct = 25;
		while (sb.n_inputs < 540)
			random_transaction();
		drain();

		write_limit(8'd2);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (sb.n_inputs < 740)
			random_transaction();
		drain();

		// run of one reading under the top limit, then undefined codes count down
		write_limit(8'd255);
		repeat (12) send_text_frame("7");
		repeat (3) send_text_frame("IIIII");
		send_item(1'b1, 8'h00);
		drain();
		repeat (8) @(posedge clk);

		$display("Checked %0d results for %0d input transactions, stable limits 5, 0, 7, 2, 255.",
		         sb.n_results, sb.n_inputs);
		$display("Frames seen: %0d weight, %0d undefined code, %0d zero; %0d stable latches.",
		         sb.n_status[sfsf_pkg::ST_WEIGHT], sb.n_status[sfsf_pkg::ST_UNDEF],
		         sb.n_status[sfsf_pkg::ST_ZERO], sb.n_latches);
		if (sb.n_errors == 0)
			$display("scale_frame_stability_filter_unit_tb passed");
		else
			$display("scale_frame_stability_filter_unit_tb failed");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/sfsf_pkg.sv
hw/rtl/sfsf_scan.sv
hw/rtl/sfsf_step.sv
hw/rtl/sfsf_obuf.sv
hw/rtl/scale_frame_stability_filter_unit.sv
bench/scale_frame_stability_filter_unit_tb.sv
